// File: hdl/wpab_pkg.sv
// shared types, constants and arithmetic helpers of the window pixel alpha blend core
`timescale 1ns / 1ps

package wpab_pkg;

	// field widths
	localparam int PIXEL_COORD_W = 12;
	localparam int COORD_BITS_DEFAULT = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_W = 17;
	localparam int DIV_STAGES = 4;
	localparam int CHANNELS = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_OPACITY = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR     = 3'd5;

	// register reset values
	localparam logic [12:0] FRAME_COLUMNS_RESET = 13'd1920;
	localparam logic [12:0] FRAME_ROWS_RESET    = 13'd1080;
	localparam logic [7:0]  OPACITY_RESET       = 8'd255;
	localparam logic [7:0]  ALPHA_MAX           = 8'd255;

	// input word
	typedef struct packed {
		logic                     mode;
		logic [PIXEL_COORD_W-1:0] pixel_col;
		logic [PIXEL_COORD_W-1:0] pixel_row;
		logic [31:0]              source_pixel;
		logic [31:0]              frame_pixel;
	} pixel_in_t;

	// result word
	typedef struct packed {
		logic        write_enable;
		logic [23:0] frame_address;
		logic [31:0] result_pixel;
	} pixel_out_t;

	// what the pipeline will write for a word
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_COPY,
		KIND_BLEND
	} write_kind_t;

	// sideband carried alongside the blend arithmetic
	typedef struct packed {
		write_kind_t kind;
		logic [23:0] addr;
		logic [31:0] word;
		logic [7:0]  oa;
	} side_t;

	// one restoring division step
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic             quo_bit;
	} div_step_t;

	// x / 255 for x below 2^24: shift-add estimate, then one correction
	function automatic logic [16:0] div255(logic [23:0] x);
		logic [24:0] t;
		logic [16:0] q;
		logic [24:0] r;
		t = {1'b0, x} + 25'(x >> 8) + 25'(x >> 16);
		q = t[24:8];
		r = {1'b0, x} - (25'({q, 8'd0}) - 25'(q));
		if (r >= 25'd255) begin
			q = q + 17'd1;
		end
		return q;
	endfunction

	// subtract the shifted divisor when it fits
	function automatic div_step_t div_step(logic [NUM_W-1:0] rem, logic [NUM_W-1:0] dvs);
		div_step_t s;
		if (rem >= dvs) begin
			s.rem = rem - dvs;
			s.quo_bit = 1'b1;
		end else begin
			s.rem = rem;
			s.quo_bit = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: hdl/wpab_div.sv
// pipelined three-channel divider: blended channel sums over output alpha, saturating at 255
`timescale 1ns / 1ps

module wpab_div (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	input  wpab_pkg::side_t                                 in_side,
	input  logic [wpab_pkg::CHANNELS-1:0][wpab_pkg::NUM_W-1:0] in_num,
	output logic                                            out_valid,
	output wpab_pkg::side_t                                 out_side,
	output logic [wpab_pkg::CHANNELS-1:0][7:0]              out_quo,
	output logic [wpab_pkg::CHANNELS-1:0]                   out_sat
);

	localparam int NS = wpab_pkg::DIV_STAGES;
	localparam int NC = wpab_pkg::CHANNELS;
	localparam int NW = wpab_pkg::NUM_W;

	logic [NS-1:0]           valid_s;
	wpab_pkg::side_t         side_s [NS];
	logic [NC-1:0][NW-1:0]   rem_s  [NS];
	logic [NC-1:0][7:0]      quo_s  [NS];
	logic [NC-1:0]           sat_s  [NS];

	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_stage
			localparam int Hi = 7 - 2 * g;

			logic                  valid_a;
			wpab_pkg::side_t       side_a;
			logic [NC-1:0][NW-1:0] rem_a;
			logic [NC-1:0][7:0]    quo_a;
			logic [NC-1:0]         sat_a;
			logic [NC-1:0][NW-1:0] rem_n;
			logic [NC-1:0][7:0]    quo_n;

			// stage input: from the ports or the previous stage
			if (g == 0) begin : g_first
				always_comb begin
					valid_a = in_valid;
					side_a = in_side;
					rem_a = in_num;
					quo_a = '0;
					for (int ch = 0; ch < NC; ch++) begin
						sat_a[ch] = in_num[ch] >= NW'({in_side.oa, 8'd0});
					end
				end
			end else begin : g_next
				always_comb begin
					valid_a = valid_s[g-1];
					side_a = side_s[g-1];
					rem_a = rem_s[g-1];
					quo_a = quo_s[g-1];
					sat_a = sat_s[g-1];
				end
			end

			// two quotient bits per stage
			always_comb begin
				wpab_pkg::div_step_t s_hi;
				wpab_pkg::div_step_t s_lo;
				for (int ch = 0; ch < NC; ch++) begin
					s_hi = wpab_pkg::div_step(rem_a[ch], NW'(side_a.oa) << Hi);
					s_lo = wpab_pkg::div_step(s_hi.rem, NW'(side_a.oa) << (Hi - 1));
					rem_n[ch] = s_lo.rem;
					quo_n[ch] = quo_a[ch];
					quo_n[ch][Hi] = s_hi.quo_bit;
					quo_n[ch][Hi-1] = s_lo.quo_bit;
				end
			end

			// stage valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else begin
					valid_s[g] <= valid_a;
				end
			end

			// stage payload
			always_ff @(posedge clk) begin
				side_s[g] <= side_a;
				rem_s[g] <= rem_n;
				quo_s[g] <= quo_n;
				sat_s[g] <= sat_a;
			end
		end
	endgenerate

	assign out_valid = valid_s[NS-1];
	assign out_side = side_s[NS-1];
	assign out_quo = quo_s[NS-1];
	assign out_sat = sat_s[NS-1];

endmodule

// File: hdl/window_pixel_alpha_blend_core.sv
// top level of the window pixel alpha blend core: clip, address, opacity and over blend
`timescale 1ns / 1ps
// done rises once a start word has passed stages 1 to 5, the divider stages and the output register
// throughput: one word per clock; busy stays low since every stage moves each cycle
// the rate is set by the ten-stage pipeline, four stages of which are the channel divider
// the receiver cannot stall: each result is on result for one cycle, marked by done
// reset clears the stage valid bits and loads the configuration register defaults

module window_pixel_alpha_blend_core #(
	parameter int COORD_BITS = wpab_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  wpab_pkg::pixel_in_t                 item,
	output logic                                done,
	output wpab_pkg::pixel_out_t                result,
	input  logic                                cfg_write,
	input  logic [wpab_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wpab_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ColBits = (COORD_BITS < wpab_pkg::PIXEL_COORD_W) ?
		COORD_BITS : wpab_pkg::PIXEL_COORD_W;
	localparam int NC = wpab_pkg::CHANNELS;

	// configuration registers
	logic [12:0] left_q, top_q, cols_q, rows_q;
	logic [7:0]  opacity_q;
	logic [31:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			top_q <= '0;
			cols_q <= wpab_pkg::FRAME_COLUMNS_RESET;
			rows_q <= wpab_pkg::FRAME_ROWS_RESET;
			opacity_q <= wpab_pkg::OPACITY_RESET;
			fill_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				wpab_pkg::REG_WINDOW_LEFT:    left_q <= cfg_data[12:0];
				wpab_pkg::REG_WINDOW_TOP:     top_q <= cfg_data[12:0];
				wpab_pkg::REG_FRAME_COLUMNS:  cols_q <= cfg_data[12:0];
				wpab_pkg::REG_FRAME_ROWS:     rows_q <= cfg_data[12:0];
				wpab_pkg::REG_WINDOW_OPACITY: opacity_q <= cfg_data[7:0];
				wpab_pkg::REG_FILL_COLOR:     fill_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	wire accept = start && !busy;

	// stage 1: frame position and source alpha times opacity
	logic [12:0] col13, row13;
	assign col13 = 13'(item.pixel_col[ColBits-1:0]);
	assign row13 = 13'(item.pixel_row[ColBits-1:0]);

	logic        valid_s1, mode_s1;
	logic [13:0] x_s1, y_s1;
	logic [15:0] aprod_s1;
	logic [31:0] src_s1, dst_s1;

	always_ff @(posedge clk) begin
		mode_s1 <= item.mode;
		x_s1 <= {left_q[12], left_q} + {1'b0, col13};
		y_s1 <= {top_q[12], top_q} + {1'b0, row13};
		aprod_s1 <= item.source_pixel[31:24] * opacity_q;
		src_s1 <= item.source_pixel;
		dst_s1 <= item.frame_pixel;
	end

	// stage 2: clip, row offset, scaled alpha and write decision
	logic        in_frame;
	logic [7:0]  a_n;
	logic [25:0] ymul;
	assign in_frame = !x_s1[13] && !y_s1[13] && (x_s1[12:0] < cols_q) && (y_s1[12:0] < rows_q);
	assign a_n = 8'(wpab_pkg::div255(24'(aprod_s1)));
	assign ymul = y_s1[12:0] * cols_q;

	logic                  valid_s2;
	wpab_pkg::write_kind_t kind_s2;
	logic [31:0]           word_s2, src_s2, dst_s2;
	logic [12:0]           x_s2;
	logic [23:0]           yprod_s2;
	logic [7:0]            a_s2;

	always_ff @(posedge clk) begin
		x_s2 <= x_s1[12:0];
		yprod_s2 <= ymul[23:0];
		a_s2 <= a_n;
		src_s2 <= src_s1;
		dst_s2 <= dst_s1;
		if (!in_frame) begin
			kind_s2 <= wpab_pkg::KIND_NONE;
			word_s2 <= src_s1;
		end else if (mode_s1) begin
			kind_s2 <= wpab_pkg::KIND_COPY;
			word_s2 <= fill_q;
		end else if (a_n == wpab_pkg::ALPHA_MAX) begin
			kind_s2 <= wpab_pkg::KIND_COPY;
			word_s2 <= src_s1;
		end else if (a_n == 8'd0) begin
			kind_s2 <= wpab_pkg::KIND_NONE;
			word_s2 <= src_s1;
		end else begin
			kind_s2 <= wpab_pkg::KIND_BLEND;
			word_s2 <= src_s1;
		end
	end

	// stage 3: address and first blend products
	logic [7:0] inv_n;
	assign inv_n = wpab_pkg::ALPHA_MAX - a_s2;

	logic                    valid_s3;
	wpab_pkg::side_t         side_s3;
	logic [7:0]              a_s3, inv_s3;
	logic [15:0]             dainv_s3;
	logic [NC-1:0][15:0]     sa_s3, dda_s3;

	always_ff @(posedge clk) begin
		side_s3.kind <= kind_s2;
		side_s3.addr <= yprod_s2 + 24'(x_s2);
		side_s3.word <= word_s2;
		side_s3.oa <= '0;
		a_s3 <= a_s2;
		inv_s3 <= inv_n;
		dainv_s3 <= dst_s2[31:24] * inv_n;
		for (int ch = 0; ch < NC; ch++) begin
			sa_s3[ch] <= src_s2[8*ch +: 8] * a_s2;
			dda_s3[ch] <= dst_s2[8*ch +: 8] * dst_s2[31:24];
		end
	end

	// stage 4: output alpha and destination weight products
	logic [8:0] oa_n;
	assign oa_n = 9'(a_s3) + 9'(wpab_pkg::div255(24'(dainv_s3)));

	logic                valid_s4;
	wpab_pkg::side_t     side_s4;
	logic [NC-1:0][15:0] sa_s4;
	logic [NC-1:0][23:0] prod3_s4;

	always_ff @(posedge clk) begin
		side_s4 <= '{kind: side_s3.kind, addr: side_s3.addr, word: side_s3.word,
			oa: oa_n[7:0]};
		sa_s4 <= sa_s3;
		for (int ch = 0; ch < NC; ch++) begin
			prod3_s4[ch] <= dda_s3[ch] * inv_s3;
		end
	end

	// stage 5: channel numerators
	logic                                 valid_s5;
	wpab_pkg::side_t                      side_s5;
	logic [NC-1:0][wpab_pkg::NUM_W-1:0]   num_s5;

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		for (int ch = 0; ch < NC; ch++) begin
			num_s5[ch] <= wpab_pkg::NUM_W'(sa_s4[ch]) + wpab_pkg::div255(prod3_s4[ch]);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// channel division over output alpha
	logic                div_valid;
	wpab_pkg::side_t     div_side;
	logic [NC-1:0][7:0]  div_quo;
	logic [NC-1:0]       div_sat;

	wpab_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s5),
		.in_side   (side_s5),
		.in_num    (num_s5),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_quo   (div_quo),
		.out_sat   (div_sat)
	);

	// result word assembly
	wpab_pkg::pixel_out_t res_n;
	always_comb begin
		res_n = '0;
		case (div_side.kind)
			wpab_pkg::KIND_COPY: begin
				res_n.write_enable = 1'b1;
				res_n.frame_address = div_side.addr;
				res_n.result_pixel = div_side.word;
			end
			wpab_pkg::KIND_BLEND: begin
				res_n.write_enable = 1'b1;
				res_n.frame_address = div_side.addr;
				res_n.result_pixel[31:24] = div_side.oa;
				for (int ch = 0; ch < NC; ch++) begin
					res_n.result_pixel[8*ch +: 8] = div_sat[ch] ? wpab_pkg::ALPHA_MAX : div_quo[ch];
				end
			end
			default: res_n = '0;
		endcase
	end

	// output register
	logic                 done_q;
	wpab_pkg::pixel_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_n;
	end

	assign done = done_q;
	assign result = result_q;

endmodule
